[rtl/core/rrts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin thread scheduler package
// Shared sizes, request and result types, operation and status codes,
// and ring index helpers.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int COUNT_W = $clog2(SLOTS + 1);
  localparam int PRI_W   = 8;
  localparam int SCALE_W = 8;
  localparam int SLICE_W = 16;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd10;

  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_SCHED  = 2'd1;
  localparam logic [1:0] MODE_EXIT   = 2'd2;
  localparam logic [1:0] MODE_WAKE   = 2'd3;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_DEAD    = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [PRI_W-1:0]  priority_req;
    logic [SLOT_W-1:0] wake_slot;
  } req_t;

  typedef struct packed {
    logic               op_ok;
    logic [SLOT_W-1:0]  new_slot;
    logic               running_valid;
    logic [SLOT_W-1:0]  running_slot;
    logic [SLICE_W-1:0] running_slice;
    logic               switched;
    logic               halted;
  } res_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] x);
    logic [SLOT_W-1:0] r;
    if (x == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = x + SLOT_W'(1);
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] x);
    logic [SLOT_W-1:0] r;
    if (x == '0) begin
      r = SLOT_W'(SLOTS - 1);
    end else begin
      r = x - SLOT_W'(1);
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0]  base,
                                                 input logic [COUNT_W-1:0] offs);
    logic [COUNT_W:0] s;
    s = {{(COUNT_W + 1 - SLOT_W){1'b0}}, base} + {1'b0, offs};
    if (s >= (COUNT_W + 1)'(SLOTS)) begin
      s = s - (COUNT_W + 1)'(SLOTS);
    end
    return s[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/rrts_req_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request stage
// Input register holding one request until the scheduler pass takes it.
// ----------------------------------------------------------------------------
module rrts_req_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire logic          req_valid,
  output      logic          req_stall,
  input  wire rrts_pkg::req_t req,
  output      logic          q_valid,
  output      rrts_pkg::req_t q
);
  import rrts_pkg::*;

  logic load;

  assign req_stall = q_valid && !advance;
  assign load      = !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (load) begin
      q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && req_valid) begin
      q <= req;
    end
  end

endmodule
`default_nettype wire

[rtl/core/rrts_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler core
// Slot tables, ready ring and running thread; one request handled per pass.
// ----------------------------------------------------------------------------
module rrts_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [rrts_pkg::SCALE_W-1:0]  cfg_wdata,
  input  wire logic                          step,
  input  wire rrts_pkg::req_t                q,
  output      rrts_pkg::res_t                res_next
);
  import rrts_pkg::*;

  logic [SCALE_W-1:0] scale;
  logic               in_use      [SLOTS];
  logic               in_use_next [SLOTS];
  logic [1:0]         status      [SLOTS];
  logic [1:0]         status_next [SLOTS];
  logic [PRI_W-1:0]   pri_tab     [SLOTS];
  logic [SLICE_W-1:0] slice_tab   [SLOTS];
  logic [SLOT_W-1:0]  ring        [SLOTS];
  logic [SLOT_W-1:0]  head, head_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [SLOT_W-1:0]  cur, cur_next;
  logic               cur_valid, cur_valid_next;
  logic               halt, halt_next;

  logic               free_found;
  logic [SLOT_W-1:0]  free_slot;
  logic               ring_full;
  logic               dispatch;
  logic [SLOT_W-1:0]  next_slot;
  logic [PRI_W-1:0]   mul_a;
  logic [SLICE_W-1:0] product;
  logic               pri_we;
  logic               slice_we;
  logic [SLOT_W-1:0]  slice_addr;
  logic               ring_we;
  logic [SLOT_W-1:0]  ring_addr;
  logic [SLOT_W-1:0]  ring_wdata;
  logic               ok;
  logic [SLOT_W-1:0]  nslot;
  logic               sw;
  logic [SLICE_W-1:0] run_slice;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  assign ring_full = (count >= COUNT_W'(SLOTS));
  assign next_slot = ring[head];
  assign mul_a     = (q.mode == MODE_CREATE) ? q.priority_req : pri_tab[cur];
  assign product   = SLICE_W'(mul_a) * SLICE_W'(scale);

  always_comb begin
    in_use_next    = in_use;
    status_next    = status;
    head_next      = head;
    count_next     = count;
    cur_next       = cur;
    cur_valid_next = cur_valid;
    halt_next      = halt;
    dispatch       = 1'b0;
    pri_we         = 1'b0;
    slice_we       = 1'b0;
    slice_addr     = free_slot;
    ring_we        = 1'b0;
    ring_addr      = slot_add(head, count);
    ring_wdata     = free_slot;
    ok             = 1'b0;
    nslot          = '0;
    sw             = 1'b0;
    if (step && !halt) begin
      unique case (q.mode)
        MODE_CREATE: begin
          if (free_found && !ring_full) begin
            in_use_next[free_slot] = 1'b1;
            status_next[free_slot] = ST_READY;
            pri_we                 = 1'b1;
            slice_we               = 1'b1;
            ring_we                = 1'b1;
            count_next             = count + COUNT_W'(1);
            ok                     = 1'b1;
            nslot                  = free_slot;
          end
        end
        MODE_SCHED: begin
          ok       = 1'b1;
          dispatch = (count != '0);
        end
        MODE_EXIT: begin
          ok = 1'b1;
          if (cur_valid) begin
            status_next[cur] = ST_DEAD;
            if (cur == '0) begin
              halt_next = 1'b1;
            end
          end
          dispatch = (count != '0) && !(cur_valid && cur == '0);
        end
        MODE_WAKE: begin
          if ({1'b0, q.wake_slot} < COUNT_W'(SLOTS) && !ring_full) begin
            status_next[q.wake_slot] = ST_READY;
            head_next                = slot_dec(head);
            ring_we                  = 1'b1;
            ring_addr                = slot_dec(head);
            ring_wdata               = q.wake_slot;
            count_next               = count + COUNT_W'(1);
            ok                       = 1'b1;
          end
        end
        default: ;
      endcase
      if (dispatch) begin
        head_next  = slot_inc(head);
        count_next = count - COUNT_W'(1);
        if (cur_valid) begin
          if (status_next[cur] == ST_RUNNING) begin
            status_next[cur] = ST_READY;
            slice_we         = 1'b1;
            slice_addr       = cur;
            ring_we          = 1'b1;
            ring_addr        = slot_add(head, count);
            ring_wdata       = cur;
            count_next       = count;
          end else if (status_next[cur] == ST_DEAD) begin
            in_use_next[cur] = 1'b0;
          end
        end
        status_next[next_slot] = ST_RUNNING;
        cur_next               = next_slot;
        cur_valid_next         = 1'b1;
        sw                     = 1'b1;
      end
    end
  end

  assign run_slice = (slice_we && slice_addr == cur_next) ? product : slice_tab[cur_next];

  always_comb begin
    res_next.op_ok         = ok;
    res_next.new_slot      = nslot;
    res_next.running_valid = cur_valid_next;
    res_next.running_slot  = cur_valid_next ? cur_next : '0;
    res_next.running_slice = cur_valid_next ? run_slice : '0;
    res_next.switched      = sw;
    res_next.halted        = halt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= SCALE_RESET;
      head      <= '0;
      count     <= '0;
      cur       <= '0;
      cur_valid <= 1'b0;
      halt      <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        in_use[i] <= 1'b0;
        status[i] <= ST_READY;
      end
    end else begin
      if (cfg_we) begin
        scale <= cfg_wdata;
      end
      head      <= head_next;
      count     <= count_next;
      cur       <= cur_next;
      cur_valid <= cur_valid_next;
      halt      <= halt_next;
      in_use    <= in_use_next;
      status    <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pri_we) begin
      pri_tab[free_slot] <= q.priority_req;
    end
    if (slice_we) begin
      slice_tab[slice_addr] <= product;
    end
    if (ring_we) begin
      ring[ring_addr] <= ring_wdata;
    end
  end

endmodule
`default_nettype wire

[rtl/core/rrts_res_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result stage
// Output register; holds a result until the receiver takes it.
// ----------------------------------------------------------------------------
module rrts_res_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load_valid,
  input  wire rrts_pkg::res_t load_res,
  input  wire logic           res_stall,
  output      logic           advance,
  output      logic           res_valid,
  output      rrts_pkg::res_t res
);
  import rrts_pkg::*;

  assign advance = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      res <= load_res;
    end
  end

endmodule
`default_nettype wire

[rtl/core/round_robin_thread_scheduler_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin thread scheduler
// Sixteen thread slots with a ready ring; create, schedule, exit and wake
// requests, one result per request.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the output is not stalled; its result
// is offered from the result register: the request is held in the input
// register while the scheduler pass (free-slot encode, one ring pop and
// push, one slice multiply) forms the value loaded into the result register.
// A stalled result holds the input register, and once that is full the input
// stalls too. Slot tables sit in flip-flops and need no clearing pass after
// reset. Write slice_scale only while the block is idle.
module round_robin_thread_scheduler_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [rrts_pkg::SCALE_W-1:0]  cfg_wdata,
  input  wire logic                          req_valid,
  output      logic                          req_stall,
  input  wire rrts_pkg::req_t                req,
  output      logic                          res_valid,
  input  wire logic                          res_stall,
  output      rrts_pkg::res_t                res
);
  import rrts_pkg::*;

  logic advance;
  logic q_valid;
  req_t q;
  res_t res_next;

  rrts_req_stage u_req (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_valid   (q_valid),
    .q         (q)
  );

  rrts_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (q_valid && advance),
    .q         (q),
    .res_next  (res_next)
  );

  rrts_res_stage u_res (
    .clk        (clk),
    .rst        (rst),
    .load_valid (q_valid),
    .load_res   (res_next),
    .res_stall  (res_stall),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

endmodule
`default_nettype wire

[rtl/core/rrts_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler port checker
// Port-level checks on results over time, bound to the top level.
// ----------------------------------------------------------------------------
module rrts_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_stall,
  input wire logic                          res_valid,
  input wire logic                          res_stall,
  input wire rrts_pkg::res_t                res
);
  import rrts_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && !res_stall) ##1 !res_stall |=> res_valid)
    else $error("result missing two cycles after request");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.halted |=> !res_valid || res.halted)
    else $error("halt cleared");

  a_switch_runs: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.switched |-> res.running_valid && res.op_ok && !res.halted)
    else $error("switch without running thread");

endmodule

bind round_robin_thread_scheduler_unit rrts_checker u_rrts_checker (.*);
`default_nettype wire

[sim/sched_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler result checker
// Watches the request, result and slice_scale ports of the round-robin
// thread scheduler, predicts every result from its own copy of the slot
// tables and ready ring, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module sched_result_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [rrts_pkg::SCALE_W-1:0] cfg_wdata,
  input  wire logic                         req_valid,
  input  wire logic                         req_stall,
  input  wire rrts_pkg::req_t               req,
  input  wire logic                         res_valid,
  input  wire logic                         res_stall,
  input  wire rrts_pkg::res_t               res,
  output int                                fail_count,
  output int                                outstanding,
  output logic                              slot0_running
);
  import rrts_pkg::*;

  localparam int EXPECT_DEPTH = 64;

  typedef struct packed {
    logic [SLOTS-1:0]              in_use;
    logic [SLOTS-1:0][1:0]         status;
    logic [SLOTS-1:0][PRI_W-1:0]   prio;
    logic [SLOTS-1:0][SLICE_W-1:0] slice;
    logic [SLOTS-1:0][SLOT_W-1:0]  ring;
    logic [SLOT_W-1:0]             head;
    logic [COUNT_W-1:0]            count;
    logic [SLOT_W-1:0]             cur;
    logic                          cur_valid;
    logic                          halt;
  } sched_state_t;

  typedef struct packed {
    sched_state_t st;
    res_t         res;
  } sched_step_t;

  sched_state_t     sched_state;
  logic [SCALE_W-1:0] scale;
  sched_step_t      step_next;
  sched_state_t     lookahead;
  res_t             predicted_res [EXPECT_DEPTH];
  int               wr_ptr;
  int               rd_ptr;
  res_t             want;
  logic             req_taken;
  logic             res_taken;

  function automatic logic [SLICE_W-1:0] scaled_slice(input logic [PRI_W-1:0] p,
                                                      input logic [SCALE_W-1:0] k);
    return SLICE_W'(p) * SLICE_W'(k);
  endfunction

  function automatic sched_state_t ring_push_tail(input sched_state_t s,
                                                  input logic [SLOT_W-1:0] slot);
    sched_state_t n;
    logic [SLOT_W-1:0] idx;
    n = s;
    if (n.count < COUNT_W'(SLOTS)) begin
      idx = SLOT_W'((int'(n.head) + int'(n.count)) % SLOTS);
      n.ring[idx] = slot;
      n.count = n.count + 1'b1;
    end
    return n;
  endfunction

  function automatic sched_state_t dispatch_head(input sched_state_t s,
                                                 input logic [SCALE_W-1:0] k);
    sched_state_t n;
    logic [SLOT_W-1:0] nx;
    logic [SLOT_W-1:0] c;
    n = s;
    if (n.count != '0) begin
      nx = n.ring[n.head];
      n.head = SLOT_W'((int'(n.head) + 1) % SLOTS);
      n.count = n.count - 1'b1;
      if (n.cur_valid) begin
        c = n.cur;
        if (n.status[c] == ST_RUNNING) begin
          n.status[c] = ST_READY;
          n.slice[c] = scaled_slice(n.prio[c], k);
          n = ring_push_tail(n, c);
        end else if (n.status[c] == ST_DEAD) begin
          n.in_use[c] = 1'b0;
        end
      end
      n.status[nx] = ST_RUNNING;
      n.cur = nx;
      n.cur_valid = 1'b1;
    end
    return n;
  endfunction

  function automatic sched_step_t advance_scheduler(input sched_state_t s, input req_t r,
                                                    input logic [SCALE_W-1:0] k);
    sched_step_t o;
    sched_state_t n;
    logic found;
    logic [SLOT_W-1:0] free_slot;
    logic [SLOT_W-1:0] c;
    n = s;
    o.res = '0;
    found = 1'b0;
    free_slot = '0;
    if (!n.halt) begin
      case (r.mode)
        MODE_CREATE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && !n.in_use[i]) begin
              found = 1'b1;
              free_slot = SLOT_W'(i);
            end
          end
          if (found && n.count < COUNT_W'(SLOTS)) begin
            n.in_use[free_slot] = 1'b1;
            n.status[free_slot] = ST_READY;
            n.prio[free_slot] = r.priority_req;
            n.slice[free_slot] = scaled_slice(r.priority_req, k);
            n = ring_push_tail(n, free_slot);
            o.res.op_ok = 1'b1;
            o.res.new_slot = free_slot;
          end
        end
        MODE_SCHED: begin
          o.res.switched = (n.count != '0);
          n = dispatch_head(n, k);
          o.res.op_ok = 1'b1;
        end
        MODE_EXIT: begin
          o.res.op_ok = 1'b1;
          if (n.cur_valid) begin
            c = n.cur;
            n.status[c] = ST_DEAD;
            if (c == '0) begin
              n.halt = 1'b1;
            end
          end
          if (!n.halt) begin
            o.res.switched = (n.count != '0);
            n = dispatch_head(n, k);
          end
        end
        MODE_WAKE: begin
          if (int'(r.wake_slot) < SLOTS && n.count < COUNT_W'(SLOTS)) begin
            n.status[r.wake_slot] = ST_READY;
            n.head = SLOT_W'((int'(n.head) + SLOTS - 1) % SLOTS);
            n.ring[n.head] = r.wake_slot;
            n.count = n.count + 1'b1;
            o.res.op_ok = 1'b1;
          end
        end
      endcase
    end
    o.res.running_valid = n.cur_valid;
    o.res.running_slot  = n.cur_valid ? n.cur : '0;
    o.res.running_slice = n.cur_valid ? n.slice[n.cur] : '0;
    o.res.halted        = n.halt;
    o.st = n;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  assign req_taken = !rst && req_valid && !req_stall;
  assign res_taken = !rst && res_valid && !res_stall;
  assign step_next = advance_scheduler(sched_state, req, scale);
  assign lookahead = req_taken ? step_next.st : sched_state;
  assign slot0_running = lookahead.cur_valid && (lookahead.cur == '0);

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      sched_state <= '0;
      scale <= SCALE_RESET;
      outstanding <= 0;
      wr_ptr = 0;
      rd_ptr = 0;
    end else begin
      if (cfg_we) begin
        scale <= cfg_wdata;
      end
      if (res_taken) begin
        if (wr_ptr == rd_ptr) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = predicted_res[rd_ptr % EXPECT_DEPTH];
          rd_ptr++;
          check_field("op_ok", 32'(want.op_ok), 32'(res.op_ok));
          check_field("new_slot", 32'(want.new_slot), 32'(res.new_slot));
          check_field("running_valid", 32'(want.running_valid), 32'(res.running_valid));
          check_field("running_slot", 32'(want.running_slot), 32'(res.running_slot));
          check_field("running_slice", 32'(want.running_slice), 32'(res.running_slice));
          check_field("switched", 32'(want.switched), 32'(res.switched));
          check_field("halted", 32'(want.halted), 32'(res.halted));
        end
      end
      if (req_taken) begin
        sched_state <= step_next.st;
        predicted_res[wr_ptr % EXPECT_DEPTH] = step_next.res;
        wr_ptr++;
      end
      outstanding <= wr_ptr - rd_ptr;
    end
  end

endmodule

[sim/round_robin_thread_scheduler_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin thread scheduler testbench
// Directed requests for full ring, missing free slot, wake and requeue
// corners, then bursts of random requests under four slice_scale settings
// with a random stalling receiver, and a final halt through exit of slot 0.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_unit_tb;
  import rrts_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [SCALE_W-1:0] cfg_wdata = '0;
  logic               req_valid = 1'b0;
  logic               req_stall;
  req_t               req = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  res_t               res;
  int                 fail_count;
  int                 outstanding;
  logic               slot0_running;

  round_robin_thread_scheduler_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  sched_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res           (res),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .slot0_running (slot0_running)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic offer(input req_t r);
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic send(input logic [1:0] m, input logic [PRI_W-1:0] p,
                      input logic [SLOT_W-1:0] w);
    req_t r;
    r.mode = m;
    r.priority_req = p;
    r.wake_slot = w;
    offer(r);
  endtask

  task automatic wait_drained;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] v);
    req_valid <= 1'b0;
    wait_drained();
    repeat (3) @(posedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: stall patterns in segments, one long hold-off to fill the block
  initial begin
    int  seg_kind;
    int  seg_len;
    int  results_seen;
    bit  held;
    results_seen = 0;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      seg_kind = $urandom_range(0, 3);
      seg_len = $urandom_range(5, 80);
      repeat (seg_len) begin
        @(posedge clk);
        if (res_valid && !res_stall) begin
          results_seen++;
        end
        if (!held && results_seen >= 450) begin
          held = 1'b1;
          res_stall <= 1'b1;
          repeat (400) @(posedge clk);
        end
        case (seg_kind)
          0: res_stall <= 1'b0;
          1: res_stall <= ($urandom_range(0, 3) == 0);
          2: res_stall <= ($urandom_range(0, 3) != 0);
          default: res_stall <= ~res_stall;
        endcase
      end
    end
  end

  initial begin
    req_t item;
    int   ph;
    int   n_sent;
    int   burst;
    int   gap;
    int   roll;
    int   lim_c;
    int   lim_s;
    int   lim_e;
    int   k;
    bit   halted_now;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // nothing running, empty ring
    send(MODE_SCHED, PRI_W'($urandom), SLOT_W'($urandom));
    send(MODE_EXIT, PRI_W'($urandom), SLOT_W'($urandom));
    // fill every slot
    send(MODE_CREATE, 8'd255, SLOT_W'($urandom));
    send(MODE_CREATE, 8'd0, SLOT_W'($urandom));
    send(MODE_CREATE, 8'd1, SLOT_W'($urandom));
    send(MODE_CREATE, 8'd128, SLOT_W'($urandom));
    send(MODE_CREATE, 8'd127, SLOT_W'($urandom));
    for (k = 5; k < SLOTS; k++) begin
      send(MODE_CREATE, PRI_W'($urandom), SLOT_W'($urandom));
    end
    // ring full: wake dropped, then a wake accepted after a dispatch
    send(MODE_WAKE, PRI_W'($urandom), 4'd3);
    send(MODE_SCHED, PRI_W'($urandom), SLOT_W'($urandom));
    send(MODE_WAKE, PRI_W'($urandom), 4'd5);
    // requeue into a full ring
    send(MODE_SCHED, PRI_W'($urandom), SLOT_W'($urandom));
    send(MODE_EXIT, PRI_W'($urandom), SLOT_W'($urandom));
    send(MODE_CREATE, 8'd7, SLOT_W'($urandom));
    // no free slot
    send(MODE_CREATE, 8'd9, SLOT_W'($urandom));
    send(MODE_EXIT, PRI_W'($urandom), SLOT_W'($urandom));
    send(MODE_WAKE, PRI_W'($urandom), 4'd9);
    // free slot but ring full
    send(MODE_CREATE, 8'd200, SLOT_W'($urandom));
    send(MODE_EXIT, PRI_W'($urandom), SLOT_W'($urandom));
    // wake the running thread, then dispatch it again
    send(MODE_WAKE, PRI_W'($urandom), 4'd9);
    send(MODE_SCHED, PRI_W'($urandom), SLOT_W'($urandom));

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_scale(8'd1);
        1: write_scale(8'd255);
        default: write_scale(SCALE_W'($urandom_range(1, 255)));
      endcase
      n_sent = 0;
      while (n_sent < 275) begin
        burst = $urandom_range(1, 32);
        case ($urandom_range(0, 4))
          0: begin lim_c = 25; lim_s = 50; lim_e = 75; end
          1: begin lim_c = 55; lim_s = 75; lim_e = 88; end
          2: begin lim_c = 15; lim_s = 40; lim_e = 85; end
          3: begin lim_c = 20; lim_s = 75; lim_e = 88; end
          default: begin lim_c = 20; lim_s = 45; lim_e = 60; end
        endcase
        for (k = 0; k < burst; k++) begin
          roll = $urandom_range(0, 99);
          item.mode = (roll < lim_c) ? MODE_CREATE :
                      (roll < lim_s) ? MODE_SCHED :
                      (roll < lim_e) ? MODE_EXIT : MODE_WAKE;
          // hold off the halt until the end
          if (item.mode == MODE_EXIT && slot0_running) begin
            item.mode = MODE_SCHED;
          end
          roll = $urandom_range(0, 9);
          item.priority_req = (roll == 0) ? '0 :
                              (roll == 1) ? '1 : PRI_W'($urandom_range(0, 255));
          item.wake_slot = SLOT_W'($urandom_range(0, SLOTS - 1));
          offer(item);
          n_sent++;
        end
        if ($urandom_range(0, 2) != 0) begin
          req_valid <= 1'b0;
          gap = $urandom_range(1, 10);
          repeat (gap) @(posedge clk);
        end
      end
    end

    // advance slot 0 to running, then exit it to halt
    halted_now = 1'b0;
    for (k = 0; k < 64 && !halted_now; k++) begin
      if (slot0_running) begin
        send(MODE_EXIT, PRI_W'($urandom), SLOT_W'($urandom));
        halted_now = 1'b1;
      end else begin
        send(MODE_SCHED, PRI_W'($urandom), SLOT_W'($urandom));
      end
    end
    for (k = 0; k < 12; k++) begin
      item.mode = 2'($urandom_range(0, 3));
      item.priority_req = PRI_W'($urandom);
      item.wake_slot = SLOT_W'($urandom);
      offer(item);
    end

    req_valid <= 1'b0;
    wait_drained();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[round_robin_thread_scheduler_unit.f]
rtl/core/rrts_pkg.sv
rtl/core/rrts_req_stage.sv
rtl/core/rrts_core.sv
rtl/core/rrts_res_stage.sv
rtl/core/round_robin_thread_scheduler_unit.sv
rtl/core/rrts_checker.sv
sim/sched_result_checker.sv
sim/round_robin_thread_scheduler_unit_tb.sv
